[hdl/tbhi_pkg.sv]
// ----------------------------------------------------------------------------
// tbhi_pkg
// Shared types and constants for the triangle height interpolator.
// ----------------------------------------------------------------------------
package tbhi_pkg;

  // classification carried with every query from front to back
  typedef struct packed {
    logic in_tri;  // point inside the triangle or on an edge
    logic degen;   // inside, but the determinant is zero
  } tbhi_flags_t;

  // entries of the queue between the front and the back
  localparam int MID_DEPTH = 8;

endpackage

[hdl/triangle_barycentric_height_interp.sv]
// ----------------------------------------------------------------------------
// triangle_barycentric_height_interp
// Throughput: one query per cycle while full is low; the divider retires one
// quotient bit per stage, so its COORD_BITS stages set most of the latency.
// Reset: both queues empty and all stages idle; no clearing pass.
// ----------------------------------------------------------------------------
module triangle_barycentric_height_interp #(
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_vert_a_x,
  input  logic signed [COORD_BITS-1:0] in_vert_a_y,
  input  logic signed [COORD_BITS-1:0] in_vert_a_z,
  input  logic signed [COORD_BITS-1:0] in_vert_b_x,
  input  logic signed [COORD_BITS-1:0] in_vert_b_y,
  input  logic signed [COORD_BITS-1:0] in_vert_b_z,
  input  logic signed [COORD_BITS-1:0] in_vert_c_x,
  input  logic signed [COORD_BITS-1:0] in_vert_c_y,
  input  logic signed [COORD_BITS-1:0] in_vert_c_z,
  output logic                         empty,
  input  logic                         pop,
  output logic                         out_inside_res,
  output logic signed [COORD_BITS-1:0] out_height,
  output logic                         out_degenerate
);
  import tbhi_pkg::*;

  localparam int N         = COORD_BITS;
  localparam int DW        = 2 * N + 2;
  localparam int MW        = 2 + 4 * DW + 4 * N;
  localparam int OW        = 2 + N;
  localparam int OUT_DEPTH = 2 ** $clog2(N + 6);
  localparam int MCW       = $clog2(MID_DEPTH + 1);
  localparam int BCW       = $clog2(OUT_DEPTH + 1);

  // front to queue
  logic                f_valid;
  tbhi_flags_t         f_flags;
  logic [DW-1:0]       f_det, f_n1, f_n2, f_n3;
  logic signed [N-1:0] f_zmin;
  logic [N-1:0]        f_dza, f_dzb, f_dzc;

  // queue to back
  logic [MW-1:0]       mid_wdata, mid_rdata;
  logic                mid_empty, mid_pop;
  tbhi_flags_t         b_flags;
  logic [DW-1:0]       b_det, b_n1, b_n2, b_n3;
  logic signed [N-1:0] b_zmin;
  logic [N-1:0]        b_dza, b_dzb, b_dzc;

  // back to result queue
  logic                r_valid, r_in_tri, r_degen;
  logic signed [N-1:0] r_height;
  logic [OW-1:0]       out_wdata, out_rdata;

  // credit counts
  logic [MCW-1:0]      fc_r, fc_nxt;
  logic [BCW-1:0]      bc_r, bc_nxt;
  logic                in_xfer, out_xfer;

  // transfers on both channels
  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;
  assign full     = (fc_r == MCW'(MID_DEPTH));
  assign mid_pop  = !mid_empty && (bc_r != BCW'(OUT_DEPTH));

  // front credits cover its stages plus the middle queue, back credits cover
  // the back pipeline plus the result queue
  assign fc_nxt = fc_r + MCW'(in_xfer) - MCW'(mid_pop);
  assign bc_nxt = bc_r + BCW'(mid_pop) - BCW'(out_xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r <= '0;
      bc_r <= '0;
    end else begin
      fc_r <= fc_nxt;
      bc_r <= bc_nxt;
    end
  end

  tbhi_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_xfer),
    .point_x  (in_point_x),
    .point_y  (in_point_y),
    .vert_a_x (in_vert_a_x),
    .vert_a_y (in_vert_a_y),
    .vert_a_z (in_vert_a_z),
    .vert_b_x (in_vert_b_x),
    .vert_b_y (in_vert_b_y),
    .vert_b_z (in_vert_b_z),
    .vert_c_x (in_vert_c_x),
    .vert_c_y (in_vert_c_y),
    .vert_c_z (in_vert_c_z),
    .q_valid  (f_valid),
    .q_flags  (f_flags),
    .q_det    (f_det),
    .q_n1     (f_n1),
    .q_n2     (f_n2),
    .q_n3     (f_n3),
    .q_zmin   (f_zmin),
    .q_dza    (f_dza),
    .q_dzb    (f_dzb),
    .q_dzc    (f_dzc)
  );

  // middle queue
  assign mid_wdata = {f_flags, f_det, f_n1, f_n2, f_n3, f_zmin, f_dza, f_dzb, f_dzc};

  tbhi_fifo #(
    .WIDTH (MW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data (mid_wdata),
    .pop       (mid_pop),
    .pop_data  (mid_rdata),
    .empty     (mid_empty)
  );

  assign {b_flags, b_det, b_n1, b_n2, b_n3, b_zmin, b_dza, b_dzb, b_dzc} = mid_rdata;

  tbhi_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (mid_pop),
    .flags      (b_flags),
    .det        (b_det),
    .n1         (b_n1),
    .n2         (b_n2),
    .n3         (b_n3),
    .zmin       (b_zmin),
    .dza        (b_dza),
    .dzb        (b_dzb),
    .dzc        (b_dzc),
    .res_valid  (r_valid),
    .res_in_tri (r_in_tri),
    .res_degen  (r_degen),
    .res_height (r_height)
  );

  // result queue
  assign out_wdata = {r_in_tri, r_degen, r_height};

  tbhi_fifo #(
    .WIDTH (OW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (r_valid),
    .push_data (out_wdata),
    .pop       (out_xfer),
    .pop_data  (out_rdata),
    .empty     (empty)
  );

  assign {out_inside_res, out_degenerate, out_height} = out_rdata;

endmodule

[hdl/tbhi_fifo.sv]
// ----------------------------------------------------------------------------
// tbhi_fifo
// Small flop-based queue, depth a power of two, read data shown while not
// empty. Writers keep it from overflowing with a credit count.
// ----------------------------------------------------------------------------
module tbhi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PTW = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             pop_ok;

  assign pop_ok = pop && !empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr_r];
  assign empty    = (cnt_r == '0);

endmodule

[hdl/tbhi_front.sv]
// ----------------------------------------------------------------------------
// tbhi_front
// Three-stage front end: edge differences and lowest height, cross products,
// then determinant and weight numerators. Classifies the point as inside or
// outside and folds the sign so the back end sees nonnegative weights.
// ----------------------------------------------------------------------------
module tbhi_front #(
  parameter int COORD_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  logic signed [COORD_BITS-1:0]   point_x,
  input  logic signed [COORD_BITS-1:0]   point_y,
  input  logic signed [COORD_BITS-1:0]   vert_a_x,
  input  logic signed [COORD_BITS-1:0]   vert_a_y,
  input  logic signed [COORD_BITS-1:0]   vert_a_z,
  input  logic signed [COORD_BITS-1:0]   vert_b_x,
  input  logic signed [COORD_BITS-1:0]   vert_b_y,
  input  logic signed [COORD_BITS-1:0]   vert_b_z,
  input  logic signed [COORD_BITS-1:0]   vert_c_x,
  input  logic signed [COORD_BITS-1:0]   vert_c_y,
  input  logic signed [COORD_BITS-1:0]   vert_c_z,
  output logic                           q_valid,
  output tbhi_pkg::tbhi_flags_t          q_flags,
  output logic [2*COORD_BITS+1:0]        q_det,
  output logic [2*COORD_BITS+1:0]        q_n1,
  output logic [2*COORD_BITS+1:0]        q_n2,
  output logic [2*COORD_BITS+1:0]        q_n3,
  output logic signed [COORD_BITS-1:0]   q_zmin,
  output logic [COORD_BITS-1:0]          q_dza,
  output logic [COORD_BITS-1:0]          q_dzb,
  output logic [COORD_BITS-1:0]          q_dzc
);
  import tbhi_pkg::*;

  localparam int N  = COORD_BITS;
  localparam int EW = N + 1;      // coordinate difference
  localparam int PW = 2 * N + 2;  // product of two differences
  localparam int W  = 2 * N + 3;  // determinant and numerators, signed
  localparam int DW = 2 * N + 2;  // magnitude after sign folding

  // stage 1: differences and height offsets
  logic signed [EW-1:0] s1_bcy_nxt, s1_acx_nxt, s1_cbx_nxt, s1_acy_nxt;
  logic signed [EW-1:0] s1_pcx_nxt, s1_pcy_nxt, s1_cay_nxt;
  logic signed [N-1:0]  s1_zmin_nxt;
  logic signed [EW-1:0] dza_w, dzb_w, dzc_w;

  logic                 s1_vld_r;
  logic signed [EW-1:0] s1_bcy_r, s1_acx_r, s1_cbx_r, s1_acy_r;
  logic signed [EW-1:0] s1_pcx_r, s1_pcy_r, s1_cay_r;
  logic signed [N-1:0]  s1_zmin_r;
  logic [N-1:0]         s1_dza_r, s1_dzb_r, s1_dzc_r;

  // stage 2: cross products
  logic signed [PW-1:0] s2_pd0_nxt, s2_pd1_nxt, s2_p10_nxt, s2_p11_nxt;
  logic signed [PW-1:0] s2_p20_nxt, s2_p21_nxt;

  logic                 s2_vld_r;
  logic signed [PW-1:0] s2_pd0_r, s2_pd1_r, s2_p10_r, s2_p11_r, s2_p20_r, s2_p21_r;
  logic signed [N-1:0]  s2_zmin_r;
  logic [N-1:0]         s2_dza_r, s2_dzb_r, s2_dzc_r;

  // stage 3: determinant and numerators
  logic signed [W-1:0]  s3_det_nxt, s3_n1_nxt, s3_n2_nxt;

  logic                 s3_vld_r;
  logic signed [W-1:0]  s3_det_r, s3_n1_r, s3_n2_r;
  logic signed [N-1:0]  s3_zmin_r;
  logic [N-1:0]         s3_dza_r, s3_dzb_r, s3_dzc_r;

  // classification
  logic signed [W-1:0]  n3_w;
  logic signed [W-1:0]  det_a, n1_a, n2_a, n3_a;
  logic                 any_pos, any_neg, tri_in, flip;

  // lowest vertex height
  always_comb begin
    s1_zmin_nxt = vert_a_z;
    if (vert_b_z < s1_zmin_nxt) begin
      s1_zmin_nxt = vert_b_z;
    end
    if (vert_c_z < s1_zmin_nxt) begin
      s1_zmin_nxt = vert_c_z;
    end
  end

  assign dza_w = EW'(vert_a_z) - EW'(s1_zmin_nxt);
  assign dzb_w = EW'(vert_b_z) - EW'(s1_zmin_nxt);
  assign dzc_w = EW'(vert_c_z) - EW'(s1_zmin_nxt);

  // edge differences
  assign s1_bcy_nxt = EW'(vert_b_y) - EW'(vert_c_y);
  assign s1_acx_nxt = EW'(vert_a_x) - EW'(vert_c_x);
  assign s1_cbx_nxt = EW'(vert_c_x) - EW'(vert_b_x);
  assign s1_acy_nxt = EW'(vert_a_y) - EW'(vert_c_y);
  assign s1_pcx_nxt = EW'(point_x)  - EW'(vert_c_x);
  assign s1_pcy_nxt = EW'(point_y)  - EW'(vert_c_y);
  assign s1_cay_nxt = EW'(vert_c_y) - EW'(vert_a_y);

  // products of differences
  assign s2_pd0_nxt = s1_bcy_r * s1_acx_r;
  assign s2_pd1_nxt = s1_cbx_r * s1_acy_r;
  assign s2_p10_nxt = s1_bcy_r * s1_pcx_r;
  assign s2_p11_nxt = s1_cbx_r * s1_pcy_r;
  assign s2_p20_nxt = s1_cay_r * s1_pcx_r;
  assign s2_p21_nxt = s1_acx_r * s1_pcy_r;

  // sums
  assign s3_det_nxt = W'(s2_pd0_r) + W'(s2_pd1_r);
  assign s3_n1_nxt  = W'(s2_p10_r) + W'(s2_p11_r);
  assign s3_n2_nxt  = W'(s2_p20_r) + W'(s2_p21_r);

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= take;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    s1_bcy_r  <= s1_bcy_nxt;
    s1_acx_r  <= s1_acx_nxt;
    s1_cbx_r  <= s1_cbx_nxt;
    s1_acy_r  <= s1_acy_nxt;
    s1_pcx_r  <= s1_pcx_nxt;
    s1_pcy_r  <= s1_pcy_nxt;
    s1_cay_r  <= s1_cay_nxt;
    s1_zmin_r <= s1_zmin_nxt;
    s1_dza_r  <= dza_w[N-1:0];
    s1_dzb_r  <= dzb_w[N-1:0];
    s1_dzc_r  <= dzc_w[N-1:0];

    s2_pd0_r  <= s2_pd0_nxt;
    s2_pd1_r  <= s2_pd1_nxt;
    s2_p10_r  <= s2_p10_nxt;
    s2_p11_r  <= s2_p11_nxt;
    s2_p20_r  <= s2_p20_nxt;
    s2_p21_r  <= s2_p21_nxt;
    s2_zmin_r <= s1_zmin_r;
    s2_dza_r  <= s1_dza_r;
    s2_dzb_r  <= s1_dzb_r;
    s2_dzc_r  <= s1_dzc_r;

    s3_det_r  <= s3_det_nxt;
    s3_n1_r   <= s3_n1_nxt;
    s3_n2_r   <= s3_n2_nxt;
    s3_zmin_r <= s2_zmin_r;
    s3_dza_r  <= s2_dza_r;
    s3_dzb_r  <= s2_dzb_r;
    s3_dzc_r  <= s2_dzc_r;
  end

  // inside when no two sub-areas have opposite signs (edges included)
  assign n3_w    = s3_det_r - s3_n1_r - s3_n2_r;
  assign any_pos = (!s3_n1_r[W-1] && (|s3_n1_r)) ||
                   (!s3_n2_r[W-1] && (|s3_n2_r)) ||
                   (!n3_w[W-1] && (|n3_w));
  assign any_neg = s3_n1_r[W-1] || s3_n2_r[W-1] || n3_w[W-1];
  assign tri_in  = !(any_pos && any_neg);

  // fold a negative determinant into positive weights
  assign flip  = s3_det_r[W-1];
  assign det_a = flip ? -s3_det_r : s3_det_r;
  assign n1_a  = flip ? -s3_n1_r  : s3_n1_r;
  assign n2_a  = flip ? -s3_n2_r  : s3_n2_r;
  assign n3_a  = flip ? -n3_w     : n3_w;

  assign q_valid        = s3_vld_r;
  assign q_flags.in_tri = tri_in;
  assign q_flags.degen  = tri_in && (s3_det_r == '0);
  assign q_det          = det_a[DW-1:0];
  assign q_n1           = n1_a[DW-1:0];
  assign q_n2           = n2_a[DW-1:0];
  assign q_n3           = n3_a[DW-1:0];
  assign q_zmin         = s3_zmin_r;
  assign q_dza          = s3_dza_r;
  assign q_dzb          = s3_dzb_r;
  assign q_dzc          = s3_dzc_r;

endmodule

[hdl/tbhi_back.sv]
// ----------------------------------------------------------------------------
// tbhi_back
// Back end: weighted height sum as split partial products, then a pipelined
// restoring divider, one quotient bit per stage, then round half away from
// zero. Never stalls; the caller only feeds it when the result queue has room.
// ----------------------------------------------------------------------------
module tbhi_back #(
  parameter int COORD_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  tbhi_pkg::tbhi_flags_t          flags,
  input  logic [2*COORD_BITS+1:0]        det,
  input  logic [2*COORD_BITS+1:0]        n1,
  input  logic [2*COORD_BITS+1:0]        n2,
  input  logic [2*COORD_BITS+1:0]        n3,
  input  logic signed [COORD_BITS-1:0]   zmin,
  input  logic [COORD_BITS-1:0]          dza,
  input  logic [COORD_BITS-1:0]          dzb,
  input  logic [COORD_BITS-1:0]          dzc,
  output logic                           res_valid,
  output logic                           res_in_tri,
  output logic                           res_degen,
  output logic signed [COORD_BITS-1:0]   res_height
);
  import tbhi_pkg::*;

  localparam int N   = COORD_BITS;
  localparam int DW  = 2 * N + 2;  // determinant and weights
  localparam int K   = N + 1;      // low half of a weight
  localparam int PPW = 2 * N + 1;  // half weight times height offset
  localparam int SW  = 2 * N + 3;  // sum of three partial products
  localparam int AW  = 3 * N + 2;  // full numerator

  logic [DW-1:0] n_in  [3];
  logic [N-1:0]  dz_in [3];

  // multiply stage
  logic [PPW-1:0]      m_pl_nxt [3];
  logic [PPW-1:0]      m_ph_nxt [3];
  logic                m_vld_r;
  logic [PPW-1:0]      m_pl_r [3];
  logic [PPW-1:0]      m_ph_r [3];
  logic [DW-1:0]       m_det_r;
  logic signed [N-1:0] m_zmin_r;
  tbhi_flags_t         m_flags_r;

  // partial sum stage
  logic [SW-1:0]       s_lo_nxt, s_hi_nxt;
  logic                s_vld_r;
  logic [SW-1:0]       s_lo_r, s_hi_r;
  logic [DW-1:0]       s_det_r;
  logic signed [N-1:0] s_zmin_r;
  tbhi_flags_t         s_flags_r;

  // divider stages, stage 0 holds the full numerator
  logic [AW-1:0]       acc_nxt;
  logic [N:0]          dv_vld_r;
  logic [AW-1:0]       dv_rem_r   [N+1];
  logic [N-1:0]        dv_q_r     [N+1];
  logic [DW-1:0]       dv_det_r   [N+1];
  logic signed [N-1:0] dv_zmin_r  [N+1];
  tbhi_flags_t         dv_flags_r [N+1];
  logic [AW-1:0]       dv_dsh     [N];
  logic [N-1:0]        dv_ge;
  logic [AW-1:0]       dv_rem_nxt [N];
  logic [N-1:0]        dv_q_nxt   [N];

  // rounding
  logic [DW:0]         r2_w, d_w;
  logic [N+1:0]        s0_w, hv_w;
  logic                inc_w;

  assign n_in[0]  = n1;
  assign n_in[1]  = n2;
  assign n_in[2]  = n3;
  assign dz_in[0] = dza;
  assign dz_in[1] = dzb;
  assign dz_in[2] = dzc;

  // split each weight in two halves to keep the multipliers narrow
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      m_pl_nxt[l] = n_in[l][K-1:0]  * dz_in[l];
      m_ph_nxt[l] = n_in[l][DW-1:K] * dz_in[l];
    end
  end

  assign s_lo_nxt = SW'(m_pl_r[0]) + SW'(m_pl_r[1]) + SW'(m_pl_r[2]);
  assign s_hi_nxt = SW'(m_ph_r[0]) + SW'(m_ph_r[1]) + SW'(m_ph_r[2]);
  assign acc_nxt  = (AW'(s_hi_r) << K) + AW'(s_lo_r);

  // one restoring step per stage, most significant quotient bit first
  always_comb begin
    for (int j = 0; j < N; j++) begin
      dv_dsh[j]     = AW'(dv_det_r[j]) << (N - 1 - j);
      dv_ge[j]      = (dv_rem_r[j] >= dv_dsh[j]);
      dv_rem_nxt[j] = dv_ge[j] ? (dv_rem_r[j] - dv_dsh[j]) : dv_rem_r[j];
      dv_q_nxt[j]   = {dv_q_r[j][N-2:0], dv_ge[j]};
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r  <= 1'b0;
      s_vld_r  <= 1'b0;
      dv_vld_r <= '0;
    end else begin
      m_vld_r  <= take;
      s_vld_r  <= m_vld_r;
      dv_vld_r <= {dv_vld_r[N-1:0], s_vld_r};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      m_pl_r[l] <= m_pl_nxt[l];
      m_ph_r[l] <= m_ph_nxt[l];
    end
    m_det_r   <= det;
    m_zmin_r  <= zmin;
    m_flags_r <= flags;

    s_lo_r    <= s_lo_nxt;
    s_hi_r    <= s_hi_nxt;
    s_det_r   <= m_det_r;
    s_zmin_r  <= m_zmin_r;
    s_flags_r <= m_flags_r;

    dv_rem_r[0]   <= acc_nxt;
    dv_q_r[0]     <= '0;
    dv_det_r[0]   <= s_det_r;
    dv_zmin_r[0]  <= s_zmin_r;
    dv_flags_r[0] <= s_flags_r;
    for (int j = 0; j < N; j++) begin
      dv_rem_r[j+1]   <= dv_rem_nxt[j];
      dv_q_r[j+1]     <= dv_q_nxt[j];
      dv_det_r[j+1]   <= dv_det_r[j];
      dv_zmin_r[j+1]  <= dv_zmin_r[j];
      dv_flags_r[j+1] <= dv_flags_r[j];
    end
  end

  // round half away from zero on the lowest height plus quotient
  assign r2_w  = {dv_rem_r[N][DW-1:0], 1'b0};
  assign d_w   = {1'b0, dv_det_r[N]};
  assign s0_w  = {{2{dv_zmin_r[N][N-1]}}, dv_zmin_r[N]} + {2'b00, dv_q_r[N]};
  assign inc_w = (r2_w > d_w) || ((r2_w == d_w) && !s0_w[N+1]);
  assign hv_w  = s0_w + (N+2)'(inc_w);

  assign res_valid  = dv_vld_r[N];
  assign res_in_tri = dv_flags_r[N].in_tri;
  assign res_degen  = dv_flags_r[N].degen;
  assign res_height = (dv_flags_r[N].in_tri && !dv_flags_r[N].degen) ?
                      hv_w[N-1:0] : '0;

endmodule

[verif/tb_triangle_barycentric_height_interp.sv]
// ----------------------------------------------------------------------------
// tb_triangle_barycentric_height_interp
// Self-checking bench for the triangle height interpolator: queries go in
// through the push/full queue, and results come back through the pop/empty
// queue. A scoreboard works out each expected result with exact wide
// arithmetic. Directed corner cases come first, then constrained-by-hand
// random triangles. Both sides idle at random, and there is one long output
// stall.
// ----------------------------------------------------------------------------
module tb_triangle_barycentric_height_interp;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB          = 20;
  localparam int MAXC        = (1 << (CB - 1)) - 1;
  localparam int MINC        = -(1 << (CB - 1));
  localparam int ITEMS       = 1500;
  localparam int PHASE_LEN   = 500;
  localparam int LATENCY     = CB + 8;
  localparam int HOLD_AT     = 1100;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t px, py;
    coord_t ax, ay, az;
    coord_t bx, by, bz;
    coord_t cx, cy, cz;
  } query_t;

  typedef struct packed {
    logic   inside_res;
    coord_t height;
    logic   degen;
  } result_t;

  // expected heights for accepted queries, oldest first
  class height_scoreboard;
    result_t expected_q[$];
    int      errors;

    function longint area2(longint x1, longint y1, longint x2, longint y2,
                           longint x3, longint y3);
      longint s;
      s = x1 * (y2 - y3) + x2 * (y3 - y1) + x3 * (y1 - y2);
      return (s < 0) ? -s : s;
    endfunction

    // exact inside test and half-away-from-zero rounded interpolation
    function result_t interpolate(query_t q);
      longint px, py, ax, ay, az, bx, by, bz, cx, cy, cz;
      longint whole, parts, det, n1, n2, n3, zmin, res;
      logic signed [127:0] acc, quo, rmd, dw;
      result_t r;
      px = longint'(q.px); py = longint'(q.py);
      ax = longint'(q.ax); ay = longint'(q.ay); az = longint'(q.az);
      bx = longint'(q.bx); by = longint'(q.by); bz = longint'(q.bz);
      cx = longint'(q.cx); cy = longint'(q.cy); cz = longint'(q.cz);
      r = '0;
      whole = area2(ax, ay, bx, by, cx, cy);
      parts = area2(px, py, bx, by, cx, cy) + area2(ax, ay, px, py, cx, cy)
            + area2(ax, ay, bx, by, px, py);
      if (whole != parts) return r;
      r.inside_res = 1'b1;
      det = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
      if (det == 0) begin
        r.degen = 1'b1;
        return r;
      end
      n1 = (by - cy) * (px - cx) + (cx - bx) * (py - cy);
      n2 = (cy - ay) * (px - cx) + (ax - cx) * (py - cy);
      if (det < 0) begin
        det = -det;
        n1  = -n1;
        n2  = -n2;
      end
      n3 = det - n1 - n2;
      zmin = az;
      if (bz < zmin) zmin = bz;
      if (cz < zmin) zmin = cz;
      acc = 128'(n1) * 128'(az - zmin) + 128'(n2) * 128'(bz - zmin)
          + 128'(n3) * 128'(cz - zmin);
      dw  = 128'(det);
      quo = acc / dw;
      rmd = acc % dw;
      res = zmin + longint'(quo);
      if (2 * rmd > dw) res++;
      else if (2 * rmd == dw && res >= 0) res++;
      r.height = res[CB-1:0];
      return r;
    endfunction

    function void note_query(query_t q);
      expected_q = {expected_q, interpolate(q)};
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: inside_res %0d height %0d degenerate %0d",
               got.inside_res, got.height, got.degen);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.inside_res !== want.inside_res) begin
        $error("inside_res mismatch: expected %0d, got %0d", want.inside_res,
               got.inside_res);
        errors++;
      end
      if (got.height !== want.height) begin
        $error("height mismatch: expected %0d, got %0d", want.height, got.height);
        errors++;
      end
      if (got.degen !== want.degen) begin
        $error("degenerate mismatch: expected %0d, got %0d", want.degen, got.degen);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   push = 1'b0;
  logic   pop = 1'b0;
  query_t cur_query = '0;
  logic   full, empty, out_inside_res, out_degenerate;
  coord_t out_height;

  height_scoreboard sb;
  int send_idle_pct = 15;
  int recv_idle_pct = 84;
  int cycles = 0;

  triangle_barycentric_height_interp #(.COORD_BITS(CB)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_point_x     (cur_query.px),
    .in_point_y     (cur_query.py),
    .in_vert_a_x    (cur_query.ax),
    .in_vert_a_y    (cur_query.ay),
    .in_vert_a_z    (cur_query.az),
    .in_vert_b_x    (cur_query.bx),
    .in_vert_b_y    (cur_query.by),
    .in_vert_b_z    (cur_query.bz),
    .in_vert_c_x    (cur_query.cx),
    .in_vert_c_y    (cur_query.cy),
    .in_vert_c_z    (cur_query.cz),
    .empty          (empty),
    .pop            (pop),
    .out_inside_res (out_inside_res),
    .out_height     (out_height),
    .out_degenerate (out_degenerate)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic query_t mk_query(int px, int py, int ax, int ay, int az,
                                      int bx, int by, int bz,
                                      int cx, int cy, int cz);
    query_t q;
    q.px = coord_t'(px); q.py = coord_t'(py);
    q.ax = coord_t'(ax); q.ay = coord_t'(ay); q.az = coord_t'(az);
    q.bx = coord_t'(bx); q.by = coord_t'(by); q.bz = coord_t'(bz);
    q.cx = coord_t'(cx); q.cy = coord_t'(cy); q.cz = coord_t'(cz);
    return q;
  endfunction

  function automatic int clip(int v);
    if (v > MAXC) return MAXC;
    if (v < MINC) return MINC;
    return v;
  endfunction

  function automatic int rnd_coord();
    return int'($urandom_range(0, (1 << CB) - 1)) + MINC;
  endfunction

  function automatic int rnd_offset(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // random query, mostly shaped so that the point lands inside or on an edge
  function automatic query_t gen_query();
    int kind, r, ox, oy, dx, dy, m, n, k;
    int v[6];
    int p[2];
    int spans[6] = '{1, 3, 15, 255, 4095, 65535};
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 6; i++) v[i] = rnd_coord();
    p[0] = rnd_coord();
    p[1] = rnd_coord();
    case (kind)
      0, 1, 2, 3: begin
        // small triangle around a random center, point in its box
        r  = spans[$urandom_range(0, 5)];
        ox = int'($urandom_range(0, (1 << CB) - 1 - 2 * r)) + MINC + r;
        oy = int'($urandom_range(0, (1 << CB) - 1 - 2 * r)) + MINC + r;
        for (int i = 0; i < 3; i++) begin
          v[2*i]   = ox + rnd_offset(r);
          v[2*i+1] = oy + rnd_offset(r);
        end
        p[0] = ox + rnd_offset(r);
        p[1] = oy + rnd_offset(r);
      end
      4: begin
        // centroid of a large triangle
        p[0] = (v[0] + v[2] + v[4]) / 3;
        p[1] = (v[1] + v[3] + v[5]) / 3;
      end
      5: begin
        // a vertex or an edge midpoint
        k = $urandom_range(0, 2);
        if ($urandom_range(0, 1)) begin
          p[0] = v[2*k];
          p[1] = v[2*k+1];
        end else begin
          p[0] = (v[0] + v[2]) >>> 1;
          p[1] = (v[1] + v[3]) >>> 1;
        end
      end
      6: begin
        // collinear vertices, point on the line or just off it
        dx = rnd_offset(8);
        dy = rnd_offset(8);
        m  = rnd_offset(50);
        n  = rnd_offset(50);
        k  = rnd_offset(50);
        v[2] = clip(v[0] + m * dx);
        v[3] = clip(v[1] + m * dy);
        v[4] = clip(v[0] + n * dx);
        v[5] = clip(v[1] + n * dy);
        p[0] = clip(v[0] + k * dx + (($urandom_range(0, 3) == 0) ? 1 : 0));
        p[1] = clip(v[1] + k * dy);
      end
      default: ;
    endcase
    return mk_query(p[0], p[1], v[0], v[1], rnd_coord(), v[2], v[3], rnd_coord(),
                    v[4], v[5], rnd_coord());
  endfunction

  // one query transfer, with random idle cycles in front
  task automatic send_query(input query_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    cur_query <= q;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_query(q);
  endtask

  // result side: random pops, one long stall to back the block up
  initial begin
    int popped;
    int stall_left;
    bit held;
    popped     = 0;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        sb.check_result('{out_inside_res, out_height, out_degenerate});
        popped++;
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!held && popped >= HOLD_AT) begin
        stall_left = HOLD_CYCLES;
        held       = 1'b1;
      end
      pop <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // reset, stimulus and end of run
  initial begin
    query_t directed[$];
    int sent;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // basic right triangle: interior, vertex, edge, outside
    directed = {directed, mk_query(1, 1, 0, 0, 10, 4, 0, 20, 0, 4, 30)};
    directed = {directed, mk_query(0, 0, 0, 0, 10, 4, 0, 20, 0, 4, 30)};
    directed = {directed, mk_query(2, 0, 0, 0, 10, 4, 0, 20, 0, 4, 30)};
    directed = {directed, mk_query(5, 5, 0, 0, 10, 4, 0, 20, 0, 4, 30)};
    // collinear vertices, point on and off their line
    directed = {directed, mk_query(2, 2, 0, 0, 5, 1, 1, 6, 3, 3, 7)};
    directed = {directed, mk_query(2, 3, 0, 0, 5, 1, 1, 6, 3, 3, 7)};
    // all vertices at the query point, and away from it
    directed = {directed, mk_query(7, -7, 7, -7, 1, 7, -7, 2, 7, -7, 3)};
    directed = {directed, mk_query(8, -7, 7, -7, 1, 7, -7, 2, 7, -7, 3)};
    // exact halves round away from zero, thirds to nearest
    directed = {directed, mk_query(1, 0, 0, 0, 0, 2, 0, 1, 0, 2, 0)};
    directed = {directed, mk_query(1, 0, 0, 0, 0, 2, 0, -1, 0, 2, 0)};
    directed = {directed, mk_query(1, 0, 0, 0, 0, 3, 0, -1, 0, 3, 0)};
    directed = {directed, mk_query(2, 0, 0, 0, 0, 3, 0, -1, 0, 3, 0)};
    directed = {directed, mk_query(1, 0, 0, 0, 0, 3, 0, 1, 0, 3, 0)};
    // clockwise winding gives a negative determinant
    directed = {directed, mk_query(1, 2, 0, 0, 100, 0, 4, 200, 4, 0, 300)};
    // full-range triangle with extreme heights
    directed = {directed, mk_query(0, 0, MINC, MINC, MINC, MAXC, MINC, MAXC,
                                   MINC, MAXC, 0)};
    directed = {directed, mk_query(MAXC, MINC, MINC, MINC, MINC, MAXC, MINC, MAXC,
                                   MINC, MAXC, 0)};
    directed = {directed, mk_query(MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC,
                                   MINC, MAXC, 0)};
    directed = {directed, mk_query(-1000, -1000, MINC, MINC, MAXC, MAXC, MINC, MINC,
                                   MINC, MAXC, MINC)};
    directed = {directed, mk_query(MINC, MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC,
                                   MINC, MAXC, MAXC)};
    // all ones and all zeros
    directed = {directed, mk_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1)};
    directed = {directed, mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};

    sent = 0;
    foreach (directed[i]) begin
      send_query(directed[i]);
      sent++;
    end
    while (sent < ITEMS) begin
      // idle mix per phase: sender light, then receiver light, then none
      if (sent >= 2 * PHASE_LEN) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sent >= PHASE_LEN) begin
        send_idle_pct = 84;
        recv_idle_pct = 15;
      end
      send_query(gen_query());
      sent++;
    end
    push <= 1'b0;

    // drain, then watch for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
